FILE: hdl/crcfe_pkg.sv
// Shared types, constants and CRC helper functions for the CRC-16/X-25 frame engine.
package crcfe_pkg;

	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_XOROUT = 16'hFFFF;
	localparam logic [1:0]  HELD_FULL  = 2'd2;

	localparam logic MODE_GENERATE = 1'b0;
	localparam logic MODE_CHECK    = 1'b1;

	// One classified request handed from the front to the back
	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] crc_final;
		logic        append;    // generate-mode frame end: CRC low/high follow the echo
		logic        last;      // check-mode frame end: echo is the final result
		logic        ok;        // check verdict, only meaningful with last
	} crcfe_job_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} crcfe_qstat_t;

	function automatic logic [7:0] flip8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7 - i] = b[i];
		end
		return r;
	endfunction

	function automatic logic [15:0] flip16(input logic [15:0] w);
		logic [15:0] r;
		for (int i = 0; i < 16; i++) begin
			r[15 - i] = w[i];
		end
		return r;
	endfunction

	// Eight MSB-first shift steps with the reflected byte folded into the top
	function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {flip8(b), 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

FILE: hdl/crcfe_front.sv
// Front end: accepts input requests, updates CRC and delay state, classifies each request.
module crcfe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                mode,
	input  logic [7:0]          data_byte,
	input  logic                frame_start,
	input  logic                frame_end,
	input  crcfe_pkg::crcfe_qstat_t qstat,
	output logic                push,
	output crcfe_pkg::crcfe_job_t   job
);
	import crcfe_pkg::*;

	logic [15:0] crc_q;
	logic [15:0] held_q;
	logic [1:0]  cnt_q;

	logic [15:0] crc_base, held_base, crc_new, held_new, crc_fin;
	logic [1:0]  cnt_base, cnt_new;
	logic        ok;

	assign in_ready = !qstat.full;
	assign push     = in_valid && in_ready;

	// Next-state for CRC register and two-byte delay
	always_comb begin
		crc_base  = frame_start ? CRC_INIT : crc_q;
		held_base = frame_start ? 16'h0000 : held_q;
		cnt_base  = frame_start ? 2'd0 : cnt_q;
		if (mode == MODE_GENERATE) begin
			crc_new  = crc_absorb(crc_base, data_byte);
			held_new = held_base;
			cnt_new  = cnt_base;
		end else begin
			crc_new  = (cnt_base >= HELD_FULL) ? crc_absorb(crc_base, held_base[15:8])
			                                   : crc_base;
			held_new = {held_base[7:0], data_byte};
			cnt_new  = (cnt_base >= HELD_FULL) ? HELD_FULL : cnt_base + 2'd1;
		end
		crc_fin = flip16(crc_new) ^ CRC_XOROUT;
		ok = (cnt_new >= HELD_FULL) && (held_new[15:8] == crc_fin[7:0])
		     && (held_new[7:0] == crc_fin[15:8]);
	end

	// Classified request towards the queue
	always_comb begin
		job.data_byte = data_byte;
		job.crc_final = crc_fin;
		job.append    = (mode == MODE_GENERATE) && frame_end;
		job.last      = (mode == MODE_CHECK) && frame_end;
		job.ok        = (mode == MODE_CHECK) && frame_end && ok;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			held_q <= 16'h0000;
			cnt_q  <= 2'd0;
		end else if (push) begin
			crc_q  <= crc_new;
			held_q <= held_new;
			cnt_q  <= cnt_new;
		end
	end

endmodule

FILE: hdl/crcfe_queue.sv
// Short request queue between front and back ends.
module crcfe_queue #(
	parameter int DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  crcfe_pkg::crcfe_job_t   wr_job,
	input  logic                    pop,
	output crcfe_pkg::crcfe_job_t   rd_job,
	output crcfe_pkg::crcfe_qstat_t qstat
);
	import crcfe_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	crcfe_job_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign qstat.full  = (cnt_q == FULL_CNT);
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign rd_job      = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

FILE: hdl/crcfe_back.sv
// Back end: expands queued requests into result requests through the output register.
module crcfe_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  crcfe_pkg::crcfe_job_t   head_job,
	input  crcfe_pkg::crcfe_qstat_t qstat,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [7:0]              out_byte,
	output logic                    out_last,
	output logic                    check_ok,
	output logic [15:0]             crc_value
);
	import crcfe_pkg::*;

	typedef enum logic [1:0] {
		PH_ECHO,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	phase_t     phase_q;
	crcfe_job_t cur_q;
	logic       out_valid_q;
	logic       advance;

	assign advance   = !out_valid_q || out_ready;
	assign pop       = advance && (phase_q == PH_ECHO) && !qstat.empty;
	assign out_valid = out_valid_q;

	// Phase sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ECHO;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			out_byte    <= 8'h00;
			out_last    <= 1'b0;
			check_ok    <= 1'b0;
			crc_value   <= 16'h0000;
		end else if (advance) begin
			case (phase_q)
				PH_ECHO: begin
					out_valid_q <= !qstat.empty;
					if (!qstat.empty) begin
						cur_q     <= head_job;
						out_byte  <= head_job.data_byte;
						out_last  <= head_job.last;
						check_ok  <= head_job.ok;
						crc_value <= head_job.crc_final;
						phase_q   <= head_job.append ? PH_CRC_LO : PH_ECHO;
					end
				end
				PH_CRC_LO: begin
					out_valid_q <= 1'b1;
					out_byte    <= cur_q.crc_final[7:0];
					out_last    <= 1'b0;
					check_ok    <= 1'b0;
					crc_value   <= cur_q.crc_final;
					phase_q     <= PH_CRC_HI;
				end
				PH_CRC_HI: begin
					out_valid_q <= 1'b1;
					out_byte    <= cur_q.crc_final[15:8];
					out_last    <= 1'b1;
					check_ok    <= 1'b0;
					crc_value   <= cur_q.crc_final;
					phase_q     <= PH_ECHO;
				end
				default: begin
					out_valid_q <= 1'b0;
					phase_q     <= PH_ECHO;
				end
			endcase
		end
	end

endmodule

FILE: hdl/crc16_x25_frame_engine.sv
// Top level of the CRC-16/X-25 frame engine.
//
// Takes one byte request per cycle while the queue has room and gives one result
// request per cycle while out_ready is high. A byte is absorbed by the front end in
// the cycle it is accepted (CRC-16/X-25: poly 0x1021, init 0xFFFF, reflected in and
// out, XOR 0xFFFF); its request is then written into the request queue and from there
// loaded into the output register. A generate-mode frame end gives three results (echo,
// CRC low, CRC high), so it holds the back end while they go out; the request queue
// between front and back (QUEUE_DEPTH entries) keeps the input flowing meanwhile.
// Sustained rate is one byte per cycle, less per short generated frame. Check mode holds
// the two newest bytes back from the CRC and flags check_ok on the last byte.
module crc16_x25_frame_engine #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic        check_ok,
	output logic [15:0] crc_value
);
	import crcfe_pkg::*;

	crcfe_job_t   push_job, head_job;
	crcfe_qstat_t qstat;
	logic         push, pop;

	// Front end
	crcfe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.frame_end   (frame_end),
		.qstat       (qstat),
		.push        (push),
		.job         (push_job)
	);

	// Request queue
	crcfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.pop    (pop),
		.rd_job (head_job),
		.qstat  (qstat)
	);

	// Back end
	crcfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_job  (head_job),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.check_ok  (check_ok),
		.crc_value (crc_value)
	);

endmodule

FILE: hdl/crcfe_checker.sv
// Port-level checker for the CRC-16/X-25 frame engine and its bind.
module crcfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        out_last,
	input logic        check_ok,
	input logic [15:0] crc_value
);

	// A stalled result request holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last)
		&& $stable(check_ok) && $stable(crc_value))
		else $error("result changed while stalled");

	// A pass verdict only ever rides on the final result of a frame
	a_ok_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && check_ok |-> out_last)
		else $error("check_ok without out_last");

	// A pass means the echoed trailing byte equals the CRC high byte
	a_ok_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && check_ok |-> out_byte == crc_value[15:8])
		else $error("check_ok but trailing byte differs from CRC high byte");

endmodule

bind crc16_x25_frame_engine crcfe_checker u_crcfe_checker (.*);
